// File: hdl/rlbs_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and defaults for the RGB565 pair to LCD byte stream block.
// No dependencies; every other file imports this package.
package rlbs_pkg;

    localparam int PIX_W         = 16;
    localparam int BYTE_W        = 8;
    localparam int CFG_DATA_W    = 8;
    localparam int CFG_INDEX_W   = 2;
    localparam int QUEUE_DEPTH   = 2;

    // Controller command codes
    localparam logic [BYTE_W-1:0] CMD_DATA_CONTROL = 8'hBC;
    localparam logic [BYTE_W-1:0] CMD_PAGE_SET     = 8'h75;
    localparam logic [BYTE_W-1:0] CMD_COLUMN_SET   = 8'h15;
    localparam logic [BYTE_W-1:0] CMD_RAM_WRITE    = 8'h5C;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REGION_WIDTH  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REGION_HEIGHT = 2'd3;

    // Register reset values
    localparam logic [BYTE_W-1:0] RST_ORIGIN   = 8'd0;
    localparam logic [BYTE_W-1:0] RST_REGION_W = 8'd132;
    localparam logic [BYTE_W-1:0] RST_REGION_H = 8'd132;

    // One classified pixel pair, handed from front to back through the queue
    typedef struct packed {
        logic              need_dc;      // first pair of a region
        logic              need_page;    // first pair of a row
        logic [BYTE_W-1:0] row;          // page address
        logic [BYTE_W-1:0] col;          // column address
        logic [BYTE_W-1:0] data0;        // R1G1
        logic [BYTE_W-1:0] data1;        // B1R2
        logic [BYTE_W-1:0] data2;        // G2B2
        logic              region_done;  // pair closes the region
    } pair_desc_t;

endpackage

// File: hdl/rlbs_pair_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one RGB565 pixel pair per transfer.
// Depends on rlbs_pkg.
interface rlbs_pair_if
    import rlbs_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_first;
    logic [PIX_W-1:0] pixel_second;

    modport source (output valid, output pixel_first, output pixel_second, input ready);
    modport sink   (input valid, input pixel_first, input pixel_second, output ready);
endinterface

// File: hdl/rlbs_byte_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one LCD controller byte per transfer.
// Depends on rlbs_pkg.
interface rlbs_byte_if
    import rlbs_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              is_command;
    logic [BYTE_W-1:0] byte_value;
    logic              last_of_item;
    logic              last_of_region;

    modport source (output valid, output is_command, output byte_value,
                    output last_of_item, output last_of_region, input ready);
    modport sink   (input valid, input is_command, input byte_value,
                    input last_of_item, input last_of_region, output ready);
endinterface

// File: hdl/rlbs_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, region tracking and pair classification.
// Depends on rlbs_pkg and rlbs_pair_if; pushes pair_desc_t into the queue.
module rlbs_front
    import rlbs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    rlbs_pair_if.sink              pixel_in,
    input  logic                   queue_full,
    output logic                   push,
    output pair_desc_t             push_desc
);

    logic [BYTE_W-1:0] origin_x_reg, origin_y_reg, width_reg, height_reg;
    logic [BYTE_W-1:0] col_off_reg, col_off_next;
    logic [BYTE_W-1:0] row_off_reg, row_off_next;
    logic              started_reg, started_next;

    logic [BYTE_W-1:0] col_off, row_off;
    logic              row_done, region_done;
    logic [PIX_W-1:0]  p1, p2;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= RST_ORIGIN;
            origin_y_reg <= RST_ORIGIN;
            width_reg    <= RST_REGION_W;
            height_reg   <= RST_REGION_H;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X:      origin_x_reg <= cfg_data;
                REG_ORIGIN_Y:      origin_y_reg <= cfg_data;
                REG_REGION_WIDTH:  width_reg    <= cfg_data;
                REG_REGION_HEIGHT: height_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign pixel_in.ready = !queue_full;
    assign push           = pixel_in.valid && !queue_full;

    // Offsets restart at zero when no region is open
    assign col_off = started_reg ? col_off_reg : '0;
    assign row_off = started_reg ? row_off_reg : '0;

    // Row and region end, compared one bit wider so nothing wraps
    assign row_done    = ({1'b0, col_off} + 9'd2) >= {1'b0, width_reg};
    assign region_done = row_done && (({1'b0, row_off} + 9'd1) >= {1'b0, height_reg});

    // Classify the pair and pack it down to RGB444
    assign p1 = pixel_in.pixel_first;
    assign p2 = pixel_in.pixel_second;
    always_comb
    begin
        push_desc.need_dc     = !started_reg;
        push_desc.need_page   = (col_off == '0);
        push_desc.row         = origin_y_reg + row_off;
        push_desc.col         = origin_x_reg + col_off;
        push_desc.data0       = {p1[15:12], p1[10:7]};
        push_desc.data1       = {p1[4:1],   p2[15:12]};
        push_desc.data2       = {p2[10:7],  p2[4:1]};
        push_desc.region_done = region_done;
    end

    // Position update for the next pair
    always_comb
    begin
        started_next = started_reg;
        col_off_next = col_off_reg;
        row_off_next = row_off_reg;
        if (push)
        begin
            if (row_done)
            begin
                col_off_next = '0;
                if (region_done)
                begin
                    row_off_next = '0;
                    started_next = 1'b0;
                end
                else
                begin
                    row_off_next = row_off + 8'd1;
                    started_next = 1'b1;
                end
            end
            else
            begin
                col_off_next = col_off + 8'd2;
                row_off_next = row_off;
                started_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            col_off_reg <= '0;
            row_off_reg <= '0;
        end
        else
        begin
            started_reg <= started_next;
            col_off_reg <= col_off_next;
            row_off_reg <= row_off_next;
        end
    end

    // A closing pair leaves no region open
    a_region_closes: assert property (@(posedge clk) disable iff (!rst_n)
        push && region_done |=> !started_reg)
        else $error("region still open after its last pair");

    // The first pair of a region always starts a row
    a_first_pair_page: assert property (@(posedge clk) disable iff (!rst_n)
        push && !started_reg |-> push_desc.need_page)
        else $error("region opened without a page-set");

endmodule

// File: hdl/rlbs_queue.sv
`timescale 1ns / 1ps
// Small descriptor queue between front and back ends.
// Depends on rlbs_pkg for pair_desc_t.
module rlbs_queue
    import rlbs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  pair_desc_t push_desc,
    output logic       full,
    input  logic       pop,
    output logic       head_valid,
    output pair_desc_t head_desc
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pair_desc_t        slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = slot_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_desc;
    end

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full) && !(pop && !head_valid))
        else $error("queue overflow or underflow");

endmodule

// File: hdl/rlbs_back.sv
`timescale 1ns / 1ps
// Back end: walks each descriptor through its byte sequence, one byte per cycle while the
// sink is ready, into a registered output. Depends on rlbs_pkg and rlbs_byte_if.
module rlbs_back
    import rlbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  pair_desc_t  head_desc,
    output logic        pop,
    rlbs_byte_if.source byte_out
);

    // Sequence steps
    localparam logic [3:0] ST_DC     = 4'd0;
    localparam logic [3:0] ST_PAGE   = 4'd1;
    localparam logic [3:0] ST_ROW0   = 4'd2;
    localparam logic [3:0] ST_ROW1   = 4'd3;
    localparam logic [3:0] ST_COLSET = 4'd4;
    localparam logic [3:0] ST_COL0   = 4'd5;
    localparam logic [3:0] ST_COL1   = 4'd6;
    localparam logic [3:0] ST_RAMWR  = 4'd7;
    localparam logic [3:0] ST_D0     = 4'd8;
    localparam logic [3:0] ST_D1     = 4'd9;
    localparam logic [3:0] ST_D2     = 4'd10;

    logic [3:0]        step_reg, step_next;
    logic              mid_reg, mid_next;
    logic [3:0]        cur_step, after_dc;
    logic              load, is_last;
    logic              cmd_sel;
    logic [BYTE_W-1:0] byte_sel;

    logic              out_valid_reg;
    logic              out_cmd_reg, out_last_item_reg, out_last_region_reg;
    logic [BYTE_W-1:0] out_byte_reg;

    // First step of a fresh descriptor
    assign after_dc = head_desc.need_page ? ST_PAGE : ST_COLSET;
    assign cur_step = mid_reg ? step_reg : (head_desc.need_dc ? ST_DC : after_dc);
    assign is_last  = (cur_step == ST_D2);
    assign load     = head_valid && (!out_valid_reg || byte_out.ready);
    assign pop      = load && is_last;

    // Byte for the current step
    always_comb
    begin
        cmd_sel  = 1'b0;
        byte_sel = '0;
        unique case (cur_step)
            ST_DC:     begin cmd_sel = 1'b1; byte_sel = CMD_DATA_CONTROL; end
            ST_PAGE:   begin cmd_sel = 1'b1; byte_sel = CMD_PAGE_SET;     end
            ST_ROW0:   byte_sel = head_desc.row;
            ST_ROW1:   byte_sel = head_desc.row + 8'd1;
            ST_COLSET: begin cmd_sel = 1'b1; byte_sel = CMD_COLUMN_SET;   end
            ST_COL0:   byte_sel = head_desc.col;
            ST_COL1:   byte_sel = head_desc.col + 8'd1;
            ST_RAMWR:  begin cmd_sel = 1'b1; byte_sel = CMD_RAM_WRITE;    end
            ST_D0:     byte_sel = head_desc.data0;
            ST_D1:     byte_sel = head_desc.data1;
            ST_D2:     byte_sel = head_desc.data2;
            default:   byte_sel = '0;
        endcase
    end

    // Step sequencer
    always_comb
    begin
        step_next = step_reg;
        mid_next  = mid_reg;
        if (load)
        begin
            mid_next  = !is_last;
            step_next = (cur_step == ST_DC) ? after_dc : cur_step + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_DC;
            mid_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            mid_reg  <= mid_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (byte_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_cmd_reg         <= cmd_sel;
            out_byte_reg        <= byte_sel;
            out_last_item_reg   <= is_last;
            out_last_region_reg <= is_last && head_desc.region_done;
        end
    end

    assign byte_out.valid          = out_valid_reg;
    assign byte_out.is_command     = out_cmd_reg;
    assign byte_out.byte_value     = out_byte_reg;
    assign byte_out.last_of_item   = out_last_item_reg;
    assign byte_out.last_of_region = out_last_region_reg;

    a_region_end_is_item_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_last_region_reg |-> out_last_item_reg)
        else $error("region end flagged on a byte that does not end its pair");

    a_mid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        mid_reg |-> head_valid)
        else $error("sequence in progress without a queued pair");

endmodule

// File: hdl/rgb565_pair_to_lcd_byte_stream.sv
`timescale 1ns / 1ps
// Top level of the RGB565 pair to LCD byte stream block: front, queue and back.
// Depends on rlbs_pkg, rlbs_pair_if, rlbs_byte_if, rlbs_front, rlbs_queue, rlbs_back.
//
//   channel    dir  handshake     payload
//   pixel_in   in   valid/ready   pixel_first[15:0], pixel_second[15:0]
//   byte_out   out  valid/ready   is_command, byte_value[7:0], last_of_item, last_of_region
//   cfg        in   cfg_wr_en     cfg_index[1:0], cfg_data[7:0]
//
// One byte leaves per cycle through the back end's output register while the sink is ready;
// a pair makes 11 bytes at a region start, 10 at a row start and 7 elsewhere in a row.
// A pair is classified in the cycle it is taken; with the back end idle its first byte
// is offered through the queue slot and then the back end's output register. The QUEUE_DEPTH-entry queue keeps input
// transfers going while the back end or the sink stalls; pixel_in.ready drops while full.
// Reset empties the queue, closes any open region and loads the register defaults.
module rgb565_pair_to_lcd_byte_stream
    import rlbs_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    rlbs_pair_if.sink              pixel_in,
    rlbs_byte_if.source            byte_out
);

    logic       push, pop, queue_full, head_valid;
    pair_desc_t push_desc, head_desc;

    rlbs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixel_in   (pixel_in),
        .queue_full (queue_full),
        .push       (push),
        .push_desc  (push_desc)
    );

    rlbs_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    rlbs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (pop),
        .byte_out   (byte_out)
    );

endmodule

// File: test/rgb565_pair_to_lcd_byte_stream_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for rgb565_pair_to_lcd_byte_stream: directed and random
// pixel pairs, in-order byte predictor, random idling and one long sink hold-off.
// Depends on rlbs_pkg, rlbs_pair_if, rlbs_byte_if and the block itself.
module rgb565_pair_to_lcd_byte_stream_tb;
    import rlbs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        pix_t p_first;
        pix_t p_second;
    } pixel_pair_t;

    typedef struct packed {
        logic              is_command;
        logic [BYTE_W-1:0] value;
        logic              item_end;
        logic              region_end;
    } lcd_byte_t;

    typedef enum logic [1:0] {
        SRC_LIGHT_SNK_HEAVY,
        SRC_HEAVY_SNK_LIGHT,
        NO_IDLE
    } idle_phase_e;

    logic clk;
    logic rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    rlbs_pair_if pixel_in();
    rlbs_byte_if byte_out();

    rgb565_pair_to_lcd_byte_stream DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel_in  (pixel_in),
        .byte_out  (byte_out)
    );

    pixel_pair_t pairs_pending[$];
    lcd_byte_t   lcd_bytes_due[$];
    pixel_pair_t next_pair;
    lcd_byte_t   due_byte;
    idle_phase_e idle_phase;
    int          mismatches;
    int          bytes_seen;
    int          cycle_count;
    logic        hold_req;
    logic        hold_seen;
    int          hold_left;

    // Predictor copy of the registers and the region walk
    logic [BYTE_W-1:0] cfg_origin_x;
    logic [BYTE_W-1:0] cfg_origin_y;
    logic [BYTE_W-1:0] cfg_width;
    logic [BYTE_W-1:0] cfg_height;
    logic [BYTE_W-1:0] walk_col_ofs;
    logic [BYTE_W-1:0] walk_row_ofs;
    logic              walk_open;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void push_lcd_byte(input logic cmd, input logic [BYTE_W-1:0] value,
                                          input logic item_end, input logic region_end);
        lcd_byte_t b;
        b.is_command = cmd;
        b.value      = value;
        b.item_end   = item_end;
        b.region_end = region_end;
        lcd_bytes_due.push_back(b);
    endfunction

    // Expected byte burst for one pixel pair; advances the region walk
    function automatic void predict_pair_bytes(input pix_t p1, input pix_t p2);
        logic [BYTE_W-1:0] col;
        logic [BYTE_W-1:0] row;
        logic              row_done;
        logic              region_done;
        if (!walk_open)
        begin
            walk_col_ofs = '0;
            walk_row_ofs = '0;
            walk_open    = 1'b1;
            push_lcd_byte(1'b1, CMD_DATA_CONTROL, 1'b0, 1'b0);
        end
        col = cfg_origin_x + walk_col_ofs;
        row = cfg_origin_y + walk_row_ofs;
        // widths of zero behave as one through the unsigned compare
        row_done    = ({1'b0, walk_col_ofs} + 9'd2) >= {1'b0, cfg_width};
        region_done = row_done && (({1'b0, walk_row_ofs} + 9'd1) >= {1'b0, cfg_height});
        if (walk_col_ofs == '0)
        begin
            push_lcd_byte(1'b1, CMD_PAGE_SET, 1'b0, 1'b0);
            push_lcd_byte(1'b0, row, 1'b0, 1'b0);
            push_lcd_byte(1'b0, row + 8'd1, 1'b0, 1'b0);
        end
        push_lcd_byte(1'b1, CMD_COLUMN_SET, 1'b0, 1'b0);
        push_lcd_byte(1'b0, col, 1'b0, 1'b0);
        push_lcd_byte(1'b0, col + 8'd1, 1'b0, 1'b0);
        push_lcd_byte(1'b1, CMD_RAM_WRITE, 1'b0, 1'b0);
        // top four bits of each channel: red 15..12, green 10..7, blue 4..1
        push_lcd_byte(1'b0, {p1[15:12], p1[10:7]}, 1'b0, 1'b0);
        push_lcd_byte(1'b0, {p1[4:1], p2[15:12]}, 1'b0, 1'b0);
        push_lcd_byte(1'b0, {p2[10:7], p2[4:1]}, 1'b1, region_done);
        if (row_done)
        begin
            walk_col_ofs = '0;
            if (region_done)
            begin
                walk_row_ofs = '0;
                walk_open    = 1'b0;
            end
            else
                walk_row_ofs = walk_row_ofs + 8'd1;
        end
        else
            walk_col_ofs = walk_col_ofs + 8'd2;
    endfunction

    function automatic logic sender_gap();
        int pct;
        pct = (idle_phase == SRC_LIGHT_SNK_HEAVY) ? 14 :
              (idle_phase == SRC_HEAVY_SNK_LIGHT) ? 67 : 0;
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic sink_gap();
        int pct;
        pct = (idle_phase == SRC_LIGHT_SNK_HEAVY) ? 67 :
              (idle_phase == SRC_HEAVY_SNK_LIGHT) ? 14 : 0;
        return $urandom_range(0, 99) < pct;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("MISMATCH byte %0d %s: got 0x%0h, want 0x%0h", bytes_seen, what, got, want);
    endtask

    // Register mirror, updated on the same edge as the block
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_origin_x <= RST_ORIGIN;
            cfg_origin_y <= RST_ORIGIN;
            cfg_width    <= RST_REGION_W;
            cfg_height   <= RST_REGION_H;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ORIGIN_X:      cfg_origin_x <= cfg_data;
                REG_ORIGIN_Y:      cfg_origin_y <= cfg_data;
                REG_REGION_WIDTH:  cfg_width    <= cfg_data;
                REG_REGION_HEIGHT: cfg_height   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pair driver: predicts on each transfer, holds valid until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_in.valid        <= 1'b0;
            pixel_in.pixel_first  <= '0;
            pixel_in.pixel_second <= '0;
            walk_col_ofs = '0;
            walk_row_ofs = '0;
            walk_open    = 1'b0;
        end
        else
        begin
            if (pixel_in.valid && pixel_in.ready)
                predict_pair_bytes(pixel_in.pixel_first, pixel_in.pixel_second);
            if (!pixel_in.valid || pixel_in.ready)
            begin
                if (pairs_pending.size() != 0 && !sender_gap())
                begin
                    next_pair = pairs_pending.pop_front();
                    pixel_in.valid        <= 1'b1;
                    pixel_in.pixel_first  <= next_pair.p_first;
                    pixel_in.pixel_second <= next_pair.p_second;
                end
                else
                    pixel_in.valid <= 1'b0;
            end
        end
    end

    // Long sink hold-off, restarted whenever hold_req toggles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_seen <= 1'b0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_req;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Byte monitor: field-by-field check against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_out.ready <= 1'b0;
        else
        begin
            if (byte_out.valid && byte_out.ready)
            begin
                if (lcd_bytes_due.size() == 0)
                    report_mismatch("unexpected byte", int'(byte_out.byte_value), 0);
                else
                begin
                    due_byte = lcd_bytes_due.pop_front();
                    if (byte_out.is_command !== due_byte.is_command)
                        report_mismatch("is_command", int'(byte_out.is_command),
                                        int'(due_byte.is_command));
                    if (byte_out.byte_value !== due_byte.value)
                        report_mismatch("byte_value", int'(byte_out.byte_value),
                                        int'(due_byte.value));
                    if (byte_out.last_of_item !== due_byte.item_end)
                        report_mismatch("last_of_item", int'(byte_out.last_of_item),
                                        int'(due_byte.item_end));
                    if (byte_out.last_of_region !== due_byte.region_end)
                        report_mismatch("last_of_region", int'(byte_out.last_of_region),
                                        int'(due_byte.region_end));
                end
                bytes_seen++;
            end
            byte_out.ready <= (hold_left == 0) && !sink_gap();
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic queue_pair(input pix_t p1, input pix_t p2);
        pixel_pair_t pp;
        pp.p_first  = p1;
        pp.p_second = p2;
        pairs_pending.push_back(pp);
    endtask

    // Block is idle once every pair is taken and every byte has come out
    task automatic wait_idle();
        @(negedge clk);
        while (pairs_pending.size() != 0 || pixel_in.valid || lcd_bytes_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_region(input logic [7:0] ox, input logic [7:0] oy,
                              input logic [7:0] w, input logic [7:0] h);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_REGION_WIDTH, w);
        write_reg(REG_REGION_HEIGHT, h);
    endtask

    function automatic logic [7:0] rand_origin();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly small regions so that they close often; the odd extreme size
    task automatic pick_region();
        int w;
        int h;
        w = $urandom_range(0, 9);
        if (w == 9)
            w = 255;
        h = $urandom_range(0, 7);
        if (h == 7)
            h = 255;
        else if (h > 4)
            h = $urandom_range(1, 4);
        set_region(rand_origin(), rand_origin(), w[7:0], h[7:0]);
    endtask

    task automatic queue_random_pairs(input int count);
        for (int i = 0; i < count; i++)
            queue_pair(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_index             = REG_ORIGIN_X;
        cfg_data              = '0;
        pixel_in.valid        = 1'b0;
        pixel_in.pixel_first  = '0;
        pixel_in.pixel_second = '0;
        byte_out.ready        = 1'b0;
        hold_req              = 1'b0;
        idle_phase            = NO_IDLE;
        mismatches            = 0;
        bytes_seen            = 0;
        cycle_count           = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset region, pixel extremes and the bits that must be dropped
        idle_phase = SRC_LIGHT_SNK_HEAVY;
        queue_pair(16'h0000, 16'h0000);
        queue_pair(16'hFFFF, 16'hFFFF);
        queue_pair(16'hFFFF, 16'h0000);
        queue_pair(16'h0000, 16'hFFFF);
        queue_pair(16'hF000, 16'h0780);
        queue_pair(16'h001E, 16'hF79E);
        queue_pair(16'h0861, 16'h0861);
        queue_pair(16'hAAAA, 16'h5555);
        wait_idle();

        // Size shrunk mid-region below the current column: row ends on the next pair;
        // origins at the top wrap the addresses
        set_region(8'd255, 8'd255, 8'd4, 8'd2);
        queue_pair(16'h1234, 16'h5678);
        queue_pair(16'h9ABC, 16'hDEF0);
        queue_pair(16'h0F0F, 16'hF0F0);
        queue_pair(16'h8001, 16'h7FFE);
        wait_idle();

        // Zero width and zero height: one pair per region
        set_region(8'd0, 8'd128, 8'd0, 8'd0);
        queue_pair(16'hC3C3, 16'h3C3C);
        queue_pair(16'h6666, 16'h9999);
        wait_idle();

        // Width one, then an odd width of three that closes on a full pair
        write_reg(REG_REGION_WIDTH, 8'd1);
        write_reg(REG_REGION_HEIGHT, 8'd1);
        queue_pair(16'h4242, 16'hBDBD);
        wait_idle();
        set_region(8'd254, 8'd1, 8'd3, 8'd255);
        queue_pair(16'h1111, 16'hEEEE);
        queue_pair(16'h2222, 16'hDDDD);
        queue_pair(16'h3333, 16'hCCCC);
        wait_idle();

        // Largest sizes, only a couple of pairs
        set_region(8'd0, 8'd0, 8'd255, 8'd255);
        queue_pair(16'hFFFF, 16'h0001);
        queue_pair(16'h8000, 16'hFFFF);
        wait_idle();

        // Random phases with the idling pattern rotated
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_phase = idle_phase_e'(ph);
            for (int part = 0; part < 2; part++)
            begin
                pick_region();
                queue_random_pairs(12);
                wait_idle();
            end
        end

        // Sink holds off while pairs keep coming, so the input stalls
        idle_phase = NO_IDLE;
        set_region(8'd16, 8'd32, 8'd6, 8'd3);
        @(negedge clk);
        hold_req = ~hold_req;
        queue_random_pairs(30);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && lcd_bytes_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
